// File: sv/glr_pkg.sv
// Package for the gradient line rasterizer: default widths, queue depth,
// command kinds and the load sequencer states. No dependencies.
`timescale 1ns / 1ps

package glr_pkg;

  localparam int COORD_BITS_DEF   = 11;
  localparam int CHANNEL_BITS_DEF = 8;
  localparam int NUM_CHANNELS     = 3;
  localparam int QUEUE_DEPTH      = 2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_kind_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_ABS,
    FR_ORIENT,
    FR_DIV_START,
    FR_DIV_WAIT,
    FR_PUSH
  } front_state_t;

endpackage

// File: sv/glr_div.sv
// Restoring divider, one quotient bit per cycle, all colour channels in parallel.
// Depends on glr_pkg for the channel count.
`timescale 1ns / 1ps

module glr_div import glr_pkg::*; #(
  parameter int DIVIDEND_BITS = CHANNEL_BITS_DEF,
  parameter int DIVISOR_BITS  = COORD_BITS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           start,
  input  logic [NUM_CHANNELS-1:0][DIVIDEND_BITS-1:0]     dividend,
  input  logic [DIVISOR_BITS-1:0]                        divisor,
  output logic                                           busy,
  output logic [NUM_CHANNELS-1:0][DIVIDEND_BITS-1:0]     quot,
  output logic [NUM_CHANNELS-1:0][DIVISOR_BITS-1:0]      rem
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [CNT_BITS-1:0]                               count;
  logic [DIVISOR_BITS-1:0]                           dvs;
  logic [NUM_CHANNELS-1:0][DIVIDEND_BITS-1:0]        work;
  logic [NUM_CHANNELS-1:0][DIVISOR_BITS-1:0]         part;
  logic [NUM_CHANNELS-1:0][DIVIDEND_BITS-1:0]        work_next;
  logic [NUM_CHANNELS-1:0][DIVISOR_BITS-1:0]         part_next;

  always_comb begin
    logic [DIVISOR_BITS:0] trial;
    logic                  ge;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      trial = {part[c], work[c][DIVIDEND_BITS-1]};
      ge    = trial >= {1'b0, dvs};
      part_next[c] = ge ? DIVISOR_BITS'(trial - {1'b0, dvs}) : trial[DIVISOR_BITS-1:0];
      work_next[c] = {work[c][DIVIDEND_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_BITS'(DIVIDEND_BITS);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      part <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= work_next;
      part <= part_next;
    end
  end

  assign quot = work;
  assign rem  = part;

endmodule

// File: sv/glr_front.sv
// Front end: accepts beats, sends steps straight on and prepares loads
// (orientation, deltas, colour steps). Depends on glr_pkg and glr_div.
`timescale 1ns / 1ps

module glr_front import glr_pkg::*; #(
  parameter int  COORD_BITS   = COORD_BITS_DEF,
  parameter int  CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter type cmd_t        = logic
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    action,
  input  logic [COORD_BITS-1:0]   x_a,
  input  logic [COORD_BITS-1:0]   y_a,
  input  logic [COORD_BITS-1:0]   x_b,
  input  logic [COORD_BITS-1:0]   y_b,
  input  logic [CHANNEL_BITS-1:0] red_a,
  input  logic [CHANNEL_BITS-1:0] green_a,
  input  logic [CHANNEL_BITS-1:0] blue_a,
  input  logic [CHANNEL_BITS-1:0] red_b,
  input  logic [CHANNEL_BITS-1:0] green_b,
  input  logic [CHANNEL_BITS-1:0] blue_b,
  output logic                    q_push,
  output cmd_t                    q_data,
  input  logic                    q_full
);

  front_state_t state, state_next;

  logic [COORD_BITS-1:0] xa, ya, xb, yb;
  logic [COORD_BITS-1:0] ax, ay;
  logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] ca, cb, acd;
  logic [NUM_CHANNELS-1:0] cneg;
  cmd_t ld;

  logic accept;
  logic div_start, div_busy;
  logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] div_quot;
  logic [NUM_CHANNELS-1:0][COORD_BITS-1:0]   div_rem;

  logic                  steep, a_first;
  logic [COORD_BITS-1:0] maj_a, maj_b, min_a, min_b, dmaj, dmin;

  assign full      = (state != FR_IDLE) || q_full;
  assign accept    = push && !full;
  assign div_start = (state == FR_DIV_START);

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (accept && cmd_kind_t'(action) == CMD_LOAD) begin
          state_next = FR_ABS;
        end
      end
      FR_ABS:       state_next = FR_ORIENT;
      FR_ORIENT:    state_next = FR_DIV_START;
      FR_DIV_START: state_next = FR_DIV_WAIT;
      FR_DIV_WAIT: begin
        if (!div_busy) begin
          state_next = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!q_full) begin
          state_next = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    q_push = (accept && cmd_kind_t'(action) == CMD_STEP) || (state == FR_PUSH && !q_full);
    q_data      = ld;
    q_data.quot = div_quot;
    q_data.rem  = div_rem;
    if (state != FR_PUSH) begin
      q_data.kind = CMD_STEP;
    end
  end

  always_comb begin
    steep   = ay > ax;
    maj_a   = steep ? ya : xa;
    maj_b   = steep ? yb : xb;
    min_a   = steep ? xa : ya;
    min_b   = steep ? xb : yb;
    dmaj    = steep ? ay : ax;
    dmin    = steep ? ax : ay;
    a_first = maj_a <= maj_b;
  end

  always_ff @(posedge clk) begin
    if (state == FR_IDLE && accept && cmd_kind_t'(action) == CMD_LOAD) begin
      xa <= x_a;
      ya <= y_a;
      xb <= x_b;
      yb <= y_b;
      ca <= {blue_a, green_a, red_a};
      cb <= {blue_b, green_b, red_b};
    end
    if (state == FR_ABS) begin
      ax <= (xb > xa) ? xb - xa : xa - xb;
      ay <= (yb > ya) ? yb - ya : ya - yb;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        cneg[c] <= cb[c] < ca[c];
        acd[c]  <= (cb[c] < ca[c]) ? ca[c] - cb[c] : cb[c] - ca[c];
      end
    end
    if (state == FR_ORIENT) begin
      ld.kind        <= CMD_LOAD;
      ld.steep       <= steep;
      ld.major_start <= a_first ? maj_a : maj_b;
      ld.major_end   <= a_first ? maj_b : maj_a;
      ld.minor_start <= a_first ? min_a : min_b;
      ld.minor_desc  <= a_first ? (min_b < min_a) : (min_a < min_b);
      ld.length      <= dmaj;
      ld.decision    <= $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
      ld.minor_twice <= {1'b0, dmin, 1'b0};
      ld.diff_twice  <= $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        ld.colour[c]     <= a_first ? ca[c] : cb[c];
        ld.colour_neg[c] <= cneg[c] ^ !a_first;
      end
      ld.quot <= '0;
      ld.rem  <= '0;
    end
  end

  glr_div #(
    .DIVIDEND_BITS(CHANNEL_BITS),
    .DIVISOR_BITS (COORD_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(acd),
    .divisor (ld.length),
    .busy    (div_busy),
    .quot    (div_quot),
    .rem     (div_rem)
  );

endmodule

// File: sv/glr_queue.sv
// Small FIFO of commands between the front end and the walker.
// Depends on glr_pkg for the default depth.
`timescale 1ns / 1ps

module glr_queue import glr_pkg::*; #(
  parameter int  DEPTH = QUEUE_DEPTH,
  parameter type cmd_t = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  cmd_t                entries [DEPTH];
  logic [PTR_BITS-1:0] rd_ptr, wr_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push, do_pop;

  assign full    = count == CNT_BITS'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

// File: sv/glr_back.sv
// Walker: Bresenham step and incremental colour quotients, one pixel per step
// command of an active line, into an output register. Depends on glr_pkg.
`timescale 1ns / 1ps

module glr_back import glr_pkg::*; #(
  parameter int  COORD_BITS   = COORD_BITS_DEF,
  parameter int  CHANNEL_BITS = CHANNEL_BITS_DEF,
  parameter type cmd_t        = logic
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    q_data,
  input  logic                    q_empty,
  output logic                    q_pop,
  output logic                    empty,
  input  logic                    pop,
  output logic [COORD_BITS-1:0]   pixel_x,
  output logic [COORD_BITS-1:0]   pixel_y,
  output logic [CHANNEL_BITS-1:0] red,
  output logic [CHANNEL_BITS-1:0] green,
  output logic [CHANNEL_BITS-1:0] blue,
  output logic                    last_pixel
);

  localparam int DW = COORD_BITS + 3;

  logic                         active, steep, desc;
  logic [COORD_BITS-1:0]        major_pos, major_end, minor_pos, length;
  logic signed [DW-1:0]         decision, diff_twice;
  logic [COORD_BITS+1:0]        minor_twice;
  logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] base, qstep, acc_q, colour_now, q_next;
  logic [NUM_CHANNELS-1:0][COORD_BITS-1:0]   rstep, acc_r, r_next;
  logic [NUM_CHANNELS-1:0]      neg;
  logic                         out_valid, last, take;

  assign empty = !out_valid;
  assign last  = major_pos == major_end;
  assign take  = !q_empty && (!out_valid || pop);
  assign q_pop = take;

  always_comb begin
    logic [COORD_BITS:0] r_sum;
    logic                wrap;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      colour_now[c] = neg[c] ? base[c] - acc_q[c] : base[c] + acc_q[c];
      r_sum         = {1'b0, acc_r[c]} + {1'b0, rstep[c]};
      wrap          = r_sum >= {1'b0, length};
      r_next[c]     = wrap ? COORD_BITS'(r_sum - {1'b0, length}) : r_sum[COORD_BITS-1:0];
      q_next[c]     = acc_q[c] + qstep[c] + CHANNEL_BITS'(wrap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take && q_data.kind == CMD_STEP && active) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (q_data.kind == CMD_LOAD) begin
          active <= 1'b1;
        end else if (active && last) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (q_data.kind == CMD_LOAD) begin
        steep       <= q_data.steep;
        desc        <= q_data.minor_desc;
        major_pos   <= q_data.major_start;
        major_end   <= q_data.major_end;
        minor_pos   <= q_data.minor_start;
        length      <= q_data.length;
        decision    <= q_data.decision;
        minor_twice <= q_data.minor_twice;
        diff_twice  <= q_data.diff_twice;
        base        <= q_data.colour;
        neg         <= q_data.colour_neg;
        qstep       <= q_data.quot;
        rstep       <= q_data.rem;
        acc_q       <= '0;
        acc_r       <= '0;
      end else if (active) begin
        pixel_x    <= steep ? minor_pos : major_pos;
        pixel_y    <= steep ? major_pos : minor_pos;
        red        <= colour_now[0];
        green      <= colour_now[1];
        blue       <= colour_now[2];
        last_pixel <= last;
        if (!last) begin
          major_pos <= major_pos + 1'b1;
          acc_q     <= q_next;
          acc_r     <= r_next;
          if (decision < 0) begin
            decision <= decision + $signed({1'b0, minor_twice});
          end else begin
            minor_pos <= desc ? minor_pos - 1'b1 : minor_pos + 1'b1;
            decision  <= decision + diff_twice;
          end
        end
      end
    end
  end

endmodule

// File: sv/gradient_line_rasterizer.sv
// Gradient line rasterizer top level: front end, command queue, walker.
// Step beats pass the queue into the output register, one per cycle while full is low.
// A load beat holds full high while the front end runs the divider and pushes the load.
// Synchronous active-high rst empties the queue and output, and leaves no line armed.
// Depends on glr_pkg, glr_front, glr_queue and glr_back.
`timescale 1ns / 1ps

module gradient_line_rasterizer import glr_pkg::*; #(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    action,
  input  logic [COORD_BITS-1:0]   x_a,
  input  logic [COORD_BITS-1:0]   y_a,
  input  logic [COORD_BITS-1:0]   x_b,
  input  logic [COORD_BITS-1:0]   y_b,
  input  logic [CHANNEL_BITS-1:0] red_a,
  input  logic [CHANNEL_BITS-1:0] green_a,
  input  logic [CHANNEL_BITS-1:0] blue_a,
  input  logic [CHANNEL_BITS-1:0] red_b,
  input  logic [CHANNEL_BITS-1:0] green_b,
  input  logic [CHANNEL_BITS-1:0] blue_b,
  output logic                    empty,
  input  logic                    pop,
  output logic [COORD_BITS-1:0]   pixel_x,
  output logic [COORD_BITS-1:0]   pixel_y,
  output logic [CHANNEL_BITS-1:0] red,
  output logic [CHANNEL_BITS-1:0] green,
  output logic [CHANNEL_BITS-1:0] blue,
  output logic                    last_pixel
);

  localparam int DW = COORD_BITS + 3;

  typedef struct packed {
    cmd_kind_t                                 kind;
    logic                                      steep;
    logic                                      minor_desc;
    logic [COORD_BITS-1:0]                     major_start;
    logic [COORD_BITS-1:0]                     major_end;
    logic [COORD_BITS-1:0]                     minor_start;
    logic [COORD_BITS-1:0]                     length;
    logic signed [DW-1:0]                      decision;
    logic [COORD_BITS+1:0]                     minor_twice;
    logic signed [DW-1:0]                      diff_twice;
    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] colour;
    logic [NUM_CHANNELS-1:0]                   colour_neg;
    logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] quot;
    logic [NUM_CHANNELS-1:0][COORD_BITS-1:0]   rem;
  } glr_cmd_t;

  logic     q_push, q_full, q_pop, q_empty;
  glr_cmd_t q_in, q_out;

  glr_front #(
    .COORD_BITS  (COORD_BITS),
    .CHANNEL_BITS(CHANNEL_BITS),
    .cmd_t       (glr_cmd_t)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .action (action),
    .x_a    (x_a),
    .y_a    (y_a),
    .x_b    (x_b),
    .y_b    (y_b),
    .red_a  (red_a),
    .green_a(green_a),
    .blue_a (blue_a),
    .red_b  (red_b),
    .green_b(green_b),
    .blue_b (blue_b),
    .q_push (q_push),
    .q_data (q_in),
    .q_full (q_full)
  );

  glr_queue #(
    .DEPTH(QUEUE_DEPTH),
    .cmd_t(glr_cmd_t)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_in),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_out),
    .empty(q_empty)
  );

  glr_back #(
    .COORD_BITS  (COORD_BITS),
    .CHANNEL_BITS(CHANNEL_BITS),
    .cmd_t       (glr_cmd_t)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_out),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .last_pixel(last_pixel)
  );

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_load_blocks: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !action) |=> full)
    else $error("front end took a beat while preparing a load");

  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("walker popped an empty queue");
`endif

endmodule

// File: sim/tb_gradient_line_rasterizer.sv
// Testbench for gradient_line_rasterizer: directed and random lines through the
// push/full and pop/empty queues, checked against an in-bench Bresenham predictor.
// Depends on glr_pkg and the rasterizer RTL only.
`timescale 1ns / 1ps

module tb_gradient_line_rasterizer;
  import glr_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int HW = CHANNEL_BITS_DEF;
  localparam int PW = 3 * HW;
  localparam int CMAX = (1 << CW) - 1;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 600;

  typedef struct packed {
    cmd_kind_t act;
    logic [CW-1:0] xa;
    logic [CW-1:0] ya;
    logic [CW-1:0] xb;
    logic [CW-1:0] yb;
    logic [2:0][HW-1:0] col_a;
    logic [2:0][HW-1:0] col_b;
  } line_cmd_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [HW-1:0] r;
    logic [HW-1:0] g;
    logic [HW-1:0] b;
    logic last;
  } pixel_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_QUARTER,
    RX_MOSTLY
  } rx_mode_t;

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic action = CMD_STEP;
  logic [CW-1:0] x_a = '0;
  logic [CW-1:0] y_a = '0;
  logic [CW-1:0] x_b = '0;
  logic [CW-1:0] y_b = '0;
  logic [HW-1:0] red_a = '0;
  logic [HW-1:0] green_a = '0;
  logic [HW-1:0] blue_a = '0;
  logic [HW-1:0] red_b = '0;
  logic [HW-1:0] green_b = '0;
  logic [HW-1:0] blue_b = '0;
  logic empty;
  logic pop = 1'b0;
  logic [CW-1:0] pixel_x;
  logic [CW-1:0] pixel_y;
  logic [HW-1:0] red;
  logic [HW-1:0] green;
  logic [HW-1:0] blue;
  logic last_pixel;

  pixel_t pix_q[$];
  int err_cnt = 0;
  int hold_left = 0;
  int stall_cnt = 0;
  int burst_left = 0;
  int line_items = 0;
  int rx_cycle = 0;
  rx_mode_t rx_mode = RX_OPEN;

  logic ln_active = 1'b0;
  logic ln_steep = 1'b0;
  logic ln_down = 1'b0;
  logic [CW-1:0] maj_pos = '0;
  logic [CW-1:0] min_pos = '0;
  logic [CW-1:0] maj_first = '0;
  logic [CW-1:0] maj_last = '0;
  int err_term = 0;
  int rise2 = 0;
  int diff2 = 0;
  logic [2:0][HW-1:0] col_lo = '0;
  logic [2:0][HW-1:0] col_hi = '0;

  gradient_line_rasterizer dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .x_a(x_a), .y_a(y_a), .x_b(x_b), .y_b(y_b),
    .red_a(red_a), .green_a(green_a), .blue_a(blue_a),
    .red_b(red_b), .green_b(green_b), .blue_b(blue_b),
    .empty(empty), .pop(pop), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .red(red), .green(green), .blue(blue), .last_pixel(last_pixel)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int coord_span(int p, int q);
    return (p > q) ? p - q : q - p;
  endfunction

  function automatic logic [HW-1:0] shade(int s, int e, int k, int n);
    if (n == 0) return HW'(s);
    return HW'(s + ((e - s) * k) / n);
  endfunction

  function automatic int near(int a, int m);
    int b;
    b = a + int'($urandom_range(0, 2 * m)) - m;
    if (b < 0 || b > CMAX) b = 2 * a - b;
    return b;
  endfunction

  function automatic logic [PW-1:0] rand_colour();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PW'($urandom());
    endcase
  endfunction

  function automatic line_cmd_t load_cmd(int xa, int ya, int xb, int yb,
                                         logic [PW-1:0] ca, logic [PW-1:0] cb);
    line_cmd_t c;
    c.act = CMD_LOAD;
    c.xa = CW'(xa);
    c.ya = CW'(ya);
    c.xb = CW'(xb);
    c.yb = CW'(yb);
    c.col_a = ca;
    c.col_b = cb;
    return c;
  endfunction

  function automatic line_cmd_t step_cmd();
    line_cmd_t c;
    c = load_cmd($urandom(), $urandom(), $urandom(), $urandom(),
                 PW'($urandom()), PW'($urandom()));
    c.act = CMD_STEP;
    return c;
  endfunction

  task automatic predict_beat(line_cmd_t c);
    int dx, dy, dmaj, dmin, k, n;
    logic [CW-1:0] ma, mb, na, nb;
    logic a_lead;
    pixel_t px;
    if (c.act == CMD_LOAD) begin
      dx = coord_span(int'(c.xa), int'(c.xb));
      dy = coord_span(int'(c.ya), int'(c.yb));
      ln_steep = dy > dx;
      ma = ln_steep ? c.ya : c.xa;
      mb = ln_steep ? c.yb : c.xb;
      na = ln_steep ? c.xa : c.ya;
      nb = ln_steep ? c.xb : c.yb;
      a_lead = ma <= mb;
      maj_first = a_lead ? ma : mb;
      maj_last = a_lead ? mb : ma;
      min_pos = a_lead ? na : nb;
      ln_down = a_lead ? (nb < na) : (na < nb);
      maj_pos = maj_first;
      dmaj = int'(maj_last) - int'(maj_first);
      dmin = coord_span(int'(na), int'(nb));
      err_term = 2 * dmin - dmaj;
      rise2 = 2 * dmin;
      diff2 = 2 * (dmin - dmaj);
      col_lo = a_lead ? c.col_a : c.col_b;
      col_hi = a_lead ? c.col_b : c.col_a;
      ln_active = 1'b1;
    end else if (ln_active) begin
      k = int'(maj_pos) - int'(maj_first);
      n = int'(maj_last) - int'(maj_first);
      px.x = ln_steep ? min_pos : maj_pos;
      px.y = ln_steep ? maj_pos : min_pos;
      px.r = shade(int'(col_lo[0]), int'(col_hi[0]), k, n);
      px.g = shade(int'(col_lo[1]), int'(col_hi[1]), k, n);
      px.b = shade(int'(col_lo[2]), int'(col_hi[2]), k, n);
      px.last = maj_pos == maj_last;
      pix_q.insert(pix_q.size(), px);
      if (px.last) begin
        ln_active = 1'b0;
      end else begin
        maj_pos = maj_pos + 1'b1;
        if (err_term < 0) begin
          err_term += rise2;
        end else begin
          min_pos = ln_down ? min_pos - 1'b1 : min_pos + 1'b1;
          err_term += diff2;
        end
      end
    end
  endtask

  task automatic send_beat(line_cmd_t c);
    push <= 1'b1;
    action <= c.act;
    x_a <= c.xa;
    y_a <= c.ya;
    x_b <= c.xb;
    y_b <= c.yb;
    red_a <= c.col_a[0];
    green_a <= c.col_a[1];
    blue_a <= c.col_a[2];
    red_b <= c.col_b[0];
    green_b <= c.col_b[1];
    blue_b <= c.col_b[2];
    do @(posedge clk); while (full);
    predict_beat(c);
  endtask

  task automatic offer(line_cmd_t c);
    if (burst_left <= 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
    end
    burst_left--;
    send_beat(c);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pix_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_step();
    offer(step_cmd());
  endtask

  task automatic test_zero_length();
    offer(load_cmd(CMAX, 0, CMAX, 0, 24'h123456, 24'hFEDCBA));
    offer(step_cmd());
    offer(step_cmd());
  endtask

  task automatic test_extremes();
    offer(load_cmd(0, 0, CMAX, CMAX, '0, '1));
    repeat (2) offer(step_cmd());
    offer(load_cmd(CMAX, 0, 0, CMAX, '1, '0));
    repeat (2) offer(step_cmd());
  endtask

  task automatic test_axis_lines();
    offer(load_cmd(5, 9, 3, 9, 24'h00FF80, 24'hFF0001));
    repeat (3) offer(step_cmd());
    offer(load_cmd(7, 6, 7, 4, 24'h0A0B0C, 24'hC0B0A0));
    repeat (3) offer(step_cmd());
    offer(load_cmd(3, 3, 1, 1, 24'hFFFFFF, 24'h000000));
    repeat (2) offer(step_cmd());
  endtask

  task automatic test_backpressure();
    wait_drained();
    @(negedge clk);
    hold_left = 300;
    @(posedge clk);
    send_beat(load_cmd(100, 50, 140, 70, rand_colour(), rand_colour()));
    repeat (41) send_beat(step_cmd());
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      offer(load_cmd($urandom_range(0, 20), CMAX - $urandom_range(0, 20),
                     $urandom_range(0, 20), CMAX - $urandom_range(0, 20),
                     rand_colour(), rand_colour()));
      repeat ($urandom_range(1, 22)) offer(step_cmd());
      wait_drained();
    end
  endtask

  task automatic draw_random_line();
    int xa, ya, xb, yb, len, steps, kind, d;
    kind = $urandom_range(0, 99);
    xa = $urandom_range(0, CMAX);
    ya = $urandom_range(0, CMAX);
    if (kind < 10) begin
      xb = $urandom_range(0, CMAX);
      yb = $urandom_range(0, CMAX);
    end else if (kind < 14) begin
      xb = near(xa, 150);
      yb = near(ya, 150);
    end else begin
      xb = near(xa, 12);
      yb = near(ya, 12);
    end
    case (kind % 9)
      0: yb = ya;
      1: xb = xa;
      2: begin
        d = coord_span(xa, xb);
        yb = (ya + d <= CMAX) ? ya + d : ya - d;
      end
      default: ;
    endcase
    len = (coord_span(xa, xb) > coord_span(ya, yb)) ? coord_span(xa, xb)
                                                    : coord_span(ya, yb);
    len++;
    if (kind < 10) steps = $urandom_range(1, 24);
    else if (kind >= 90) steps = $urandom_range(1, len);
    else steps = len + ($urandom_range(0, 9) == 0);
    offer(load_cmd(xa, ya, xb, yb, rand_colour(), rand_colour()));
    repeat (steps) offer(step_cmd());
    line_items += 1 + steps;
  endtask

  task automatic test_random_lines();
    while (line_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: offer(step_cmd());
        1: offer(load_cmd($urandom(), $urandom(), $urandom(), $urandom(),
                          rand_colour(), rand_colour()));
        default: draw_random_line();
      endcase
    end
  endtask

  always @(posedge clk) begin
    pixel_t got, want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got = '{pixel_x, pixel_y, red, green, blue, last_pixel};
        if (pix_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected pixel x=%0d y=%0d rgb=%h/%h/%h last=%b",
                     got.x, got.y, got.r, got.g, got.b, got.last);
        end else begin
          want = pix_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("pixel mismatch: exp x=%0d y=%0d rgb=%h/%h/%h last=%b",
                       want.x, want.y, want.r, want.g, want.b, want.last);
              $display("                got x=%0d y=%0d rgb=%h/%h/%h last=%b",
                       got.x, got.y, got.r, got.g, got.b, got.last);
            end
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN: pop <= 1'b1;
          RX_COIN: pop <= 1'($urandom_range(0, 1));
          RX_QUARTER: pop <= (rx_cycle % 4 == 0);
          RX_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_step();
    test_zero_length();
    test_extremes();
    test_axis_lines();
    test_backpressure();
    test_drain_pause();
    test_random_lines();
    wait_drained();
    repeat (30) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: gradient_line_rasterizer.f
sv/glr_pkg.sv
sv/glr_div.sv
sv/glr_front.sv
sv/glr_queue.sv
sv/glr_back.sv
sv/gradient_line_rasterizer.sv
sim/tb_gradient_line_rasterizer.sv
